[sv/assert_macros.svh]
// Assertion macros for the packet slot FIFO.
// Expect clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/psf_pkg.sv]
// Package of the packet slot FIFO: codes, field widths, controller types.
// No dependencies.
package psf_pkg;

	localparam int BYTE_W    = 8;
	localparam int STAT_W    = 3;
	localparam int SIU_W     = 5;
	localparam int MAXB_W    = 7;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 8;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_DATA   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_STORED = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_LONG   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SLOTS     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES = 4'd1;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_STREAM = 2'b10
	} psf_state_t;

	typedef struct packed {
		logic push;
		logic pop_empty;
		logic pop_start;
		logic pop_done;
		logic stream;
	} psf_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic rd_done;
		logic s1_vld;
		logic out_free;
	} psf_stat_t;

endpackage

[sv/psf_req_if.sv]
// Input item channel of the packet slot FIFO.
// Depends on psf_pkg.
interface psf_req_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [psf_pkg::BYTE_W-1:0]   data_byte;
	logic                         end_of_packet;

	modport source (output valid, command, data_byte, end_of_packet, input ready);
	modport sink (input valid, command, data_byte, end_of_packet, output ready);
endinterface

[sv/psf_rsp_if.sv]
// Result item channel of the packet slot FIFO.
// Depends on psf_pkg.
interface psf_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [psf_pkg::STAT_W-1:0]   status;
	logic [psf_pkg::BYTE_W-1:0]   out_byte;
	logic                         last;

	modport source (output valid, status, out_byte, last, input ready);
	modport sink (input valid, status, out_byte, last, output ready);
endinterface

[sv/psf_cfg_if.sv]
// Register write channel of the packet slot FIFO.
// Depends on psf_pkg.
interface psf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [psf_pkg::CFG_IDX_W-1:0]   index;
	logic [psf_pkg::CFG_DAT_W-1:0]   wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

[sv/psf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/psf_ctrl.sv]
// Controller of the packet slot FIFO: idle / stream state machine.
// Depends on psf_pkg.
module psf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_cmd,
	output logic                item_ready,
	input  psf_pkg::psf_stat_t  stat,
	output psf_pkg::psf_cmd_t   cmd
);

	psf_pkg::psf_state_t state_q, state_d;
	logic accept;
	logic done;

	assign item_ready = (state_q == psf_pkg::S_IDLE) && stat.out_free;
	assign accept     = item_valid && item_ready;
	assign done       = stat.rd_done && (!stat.s1_vld || stat.out_free);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			psf_pkg::S_IDLE: begin
				if (accept) begin
					if (item_cmd == psf_pkg::CMD_PUSH) begin
						cmd.push = 1'b1;
					end else if (stat.count_zero) begin
						cmd.pop_empty = 1'b1;
					end else begin
						cmd.pop_start = 1'b1;
						state_d       = psf_pkg::S_STREAM;
					end
				end
			end
			psf_pkg::S_STREAM: begin
				cmd.stream = 1'b1;
				if (done) begin
					cmd.pop_done = 1'b1;
					state_d      = psf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = psf_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/psf_dp.sv]
// Datapath of the packet slot FIFO: ring pointers, slot and length RAMs,
// read pipeline and result register. Depends on psf_pkg and psf_ram.
module psf_dp #(
	parameter int SLOTS      = 16,
	parameter int SLOT_BYTES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr,
	input  logic [psf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psf_pkg::CFG_DAT_W-1:0]     cfg_wdata,
	input  logic [psf_pkg::BYTE_W-1:0]        data_byte,
	input  logic                              end_of_packet,
	input  psf_pkg::psf_cmd_t                 cmd,
	output psf_pkg::psf_stat_t                stat,
	input  logic                              rsp_ready,
	output logic                              rsp_valid,
	output logic [psf_pkg::STAT_W-1:0]        status,
	output logic [psf_pkg::BYTE_W-1:0]        out_byte,
	output logic                              last
);

	localparam int HW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int XW    = (CW + 1 > psf_pkg::SIU_W) ? CW + 1 : psf_pkg::SIU_W;
	localparam int OW    = $clog2(SLOT_BYTES + 2);
	localparam int LW    = $clog2(SLOT_BYTES + 1);
	localparam int AW    = $clog2(SLOTS * SLOT_BYTES);
	localparam int MW    = psf_pkg::MAXB_W + 1;
	localparam int SIU_RST = (SLOTS < 16) ? SLOTS : 16;

	logic [psf_pkg::SIU_W-1:0]  siu_q;
	logic [psf_pkg::MAXB_W-1:0] maxb_q;
	logic [HW-1:0]              head_q;
	logic [CW-1:0]              count_q;
	logic [OW-1:0]              woff_q;
	logic                       full_q;
	logic [OW-1:0]              rd_idx_q;
	logic                       s1_vld_q;
	logic                       s1_last_q;
	logic                       out_vld_q;
	logic [psf_pkg::STAT_W-1:0] out_st_q;
	logic [psf_pkg::BYTE_W-1:0] out_byte_q;
	logic                       out_last_q;

	logic [psf_pkg::SIU_W-1:0]  siu_new;
	logic [psf_pkg::MAXB_W-1:0] maxb_new;
	logic [XW-1:0]              slot_sum;
	logic [XW-1:0]              slot_x;
	logic [HW-1:0]              slot;
	logic [XW-1:0]              head_inc;
	logic [HW-1:0]              head_nxt;
	logic                       ring_full;
	logic                       full_now;
	logic [OW-1:0]              woff_nxt;
	logic                       too_long;
	logic                       store_ok;
	logic                       eop_push;
	logic [psf_pkg::STAT_W-1:0] push_st;
	logic                       st_we;
	logic [AW-1:0]              st_waddr;
	logic [AW-1:0]              st_raddr;
	logic [psf_pkg::BYTE_W-1:0] st_rdata;
	logic [LW-1:0]              len_rdata;
	logic [OW-1:0]              len_cur;
	logic                       rd_done;
	logic                       adv;
	logic                       issue;
	logic                       s1_move;
	logic                       load_res;
	logic [psf_pkg::STAT_W-1:0] res_st;

	// register clamps
	always_comb begin
		siu_new = cfg_wdata[psf_pkg::SIU_W-1:0];
		if (siu_new == '0) begin
			siu_new = psf_pkg::SIU_W'(1);
		end else if (32'(siu_new) > SLOTS) begin
			siu_new = psf_pkg::SIU_W'(SLOTS);
		end
		maxb_new = cfg_wdata[psf_pkg::MAXB_W-1:0];
		if (maxb_new == '0) begin
			maxb_new = psf_pkg::MAXB_W'(1);
		end else if (32'(maxb_new) > SLOT_BYTES) begin
			maxb_new = psf_pkg::MAXB_W'(SLOT_BYTES);
		end
	end

	// slot of the packet being pushed: head plus count, wrapped
	assign slot_sum = XW'(head_q) + XW'(count_q);
	assign slot_x   = (slot_sum >= XW'(siu_q)) ? slot_sum - XW'(siu_q) : slot_sum;
	assign slot     = slot_x[HW-1:0];
	assign head_inc = XW'(head_q) + XW'(1);
	assign head_nxt = (head_inc == XW'(siu_q)) ? '0 : head_inc[HW-1:0];

	assign ring_full = XW'(count_q) >= XW'(siu_q);
	assign full_now  = full_q || ((woff_q == '0) && ring_full);
	assign woff_nxt  = (woff_q <= OW'(SLOT_BYTES)) ? woff_q + OW'(1) : woff_q;
	assign too_long  = MW'(woff_nxt) > MW'(maxb_q);
	assign store_ok  = !too_long && !full_now;
	assign eop_push  = cmd.push && end_of_packet;

	always_comb begin
		if (too_long) begin
			push_st = psf_pkg::STAT_LONG;
		end else if (full_now) begin
			push_st = psf_pkg::STAT_FULL;
		end else begin
			push_st = psf_pkg::STAT_STORED;
		end
	end

	assign st_we    = cmd.push && !full_now && (woff_q < OW'(SLOT_BYTES));
	assign st_waddr = AW'(slot) * AW'(SLOT_BYTES) + AW'(woff_q);
	assign st_raddr = AW'(head_q) * AW'(SLOT_BYTES) + AW'(rd_idx_q);

	psf_ram #(
		.WIDTH (psf_pkg::BYTE_W),
		.DEPTH (SLOTS * SLOT_BYTES)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (data_byte),
		.re    (issue),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	psf_ram #(
		.WIDTH (LW),
		.DEPTH (SLOTS)
	) u_lengths (
		.clk   (clk),
		.we    (eop_push && store_ok),
		.waddr (slot),
		.wdata (LW'(woff_nxt)),
		.re    (cmd.pop_start),
		.raddr (head_q),
		.rdata (len_rdata)
	);

	always_comb begin
		len_cur = OW'(len_rdata);
		if (len_rdata == '0) begin
			len_cur = OW'(1);
		end else if (32'(len_rdata) > SLOT_BYTES) begin
			len_cur = OW'(SLOT_BYTES);
		end
	end

	assign rd_done  = rd_idx_q == len_cur;
	assign adv      = !out_vld_q || rsp_ready;
	assign issue    = cmd.stream && !rd_done && (!s1_vld_q || adv);
	assign s1_move  = s1_vld_q && adv;
	assign load_res = eop_push || cmd.pop_empty;
	assign res_st   = cmd.pop_empty ? psf_pkg::STAT_EMPTY : push_st;

	assign stat.count_zero = count_q == '0;
	assign stat.rd_done    = rd_done;
	assign stat.s1_vld     = s1_vld_q;
	assign stat.out_free   = adv;

	// ring state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			siu_q   <= psf_pkg::SIU_W'(SIU_RST);
			maxb_q  <= psf_pkg::MAXB_W'(SLOT_BYTES);
			head_q  <= '0;
			count_q <= '0;
			woff_q  <= '0;
			full_q  <= 1'b0;
		end else if (cfg_wr && (cfg_index == psf_pkg::REG_SLOTS)) begin
			siu_q   <= siu_new;
			head_q  <= '0;
			count_q <= '0;
			woff_q  <= '0;
			full_q  <= 1'b0;
		end else begin
			if (cfg_wr && (cfg_index == psf_pkg::REG_MAX_BYTES)) begin
				maxb_q <= maxb_new;
			end
			if (cmd.push) begin
				if (end_of_packet) begin
					woff_q <= '0;
					full_q <= 1'b0;
					if (store_ok) begin
						count_q <= count_q + CW'(1);
					end
				end else begin
					woff_q <= woff_nxt;
					full_q <= full_now;
				end
			end
			if (cmd.pop_done) begin
				head_q  <= head_nxt;
				count_q <= count_q - CW'(1);
			end
		end
	end

	// read pipeline and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.pop_start) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + OW'(1);
			end
			if (issue) begin
				s1_vld_q <= 1'b1;
			end else if (s1_move) begin
				s1_vld_q <= 1'b0;
			end
			if (load_res || s1_move) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (issue) begin
			s1_last_q <= (rd_idx_q + OW'(1)) == len_cur;
		end
		if (load_res) begin
			out_st_q   <= res_st;
			out_byte_q <= '0;
			out_last_q <= 1'b1;
		end else if (s1_move) begin
			out_st_q   <= psf_pkg::STAT_DATA;
			out_byte_q <= st_rdata;
			out_last_q <= s1_last_q;
		end
	end

	assign rsp_valid = out_vld_q;
	assign status    = out_st_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;

endmodule

[sv/packet_slot_fifo.sv]
// channel  dir  accepted when           payload
// req      in   req.valid & req.ready   command, data_byte, end_of_packet
// rsp      out  rsp.valid & rsp.ready   status, out_byte, last
// cfg      in   cfg.valid & cfg.ready   index, wdata (cfg.ready is always high)
//
// Push: the final byte's status goes to the result register. Pop: length RAM read, one
// slot RAM read per byte, then drain. Empty pop: an EMPTY status goes to the result
// register. req.ready is low while a pop streams and while the result register holds
// an item that is not taken. Reset clears pointers and control and loads cfg defaults.
// Top level of the packet slot FIFO. Depends on psf_pkg, the channel
// interfaces, psf_ctrl, psf_dp and assert_macros.svh.
`include "assert_macros.svh"

module packet_slot_fifo #(
	parameter int SLOTS      = 16,
	parameter int SLOT_BYTES = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	psf_req_if.sink   req,
	psf_rsp_if.source rsp,
	psf_cfg_if.sink   cfg
);

	psf_pkg::psf_cmd_t  cmd;
	psf_pkg::psf_stat_t stat;
	logic               req_take;
	logic               pop_take;
	logic               rsp_hold;

	assign cfg.ready = 1'b1;

	psf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (req.valid),
		.item_cmd   (req.command),
		.item_ready (req.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	psf_dp #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg.valid && cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_wdata     (cfg.wdata),
		.data_byte     (req.data_byte),
		.end_of_packet (req.end_of_packet),
		.cmd           (cmd),
		.stat          (stat),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.status        (rsp.status),
		.out_byte      (rsp.out_byte),
		.last          (rsp.last)
	);

	assign req_take = req.valid && req.ready;
	assign pop_take = req_take && (req.command == psf_pkg::CMD_POP);
	assign rsp_hold = rsp.valid && !rsp.ready;

	`PSF_ASSERT_IMP(a_no_accept_in_stream, req.ready, !cmd.stream, "item accepted during pop")
	`PSF_ASSERT_IMP(a_no_clobber, req_take, !rsp_hold, "held result overwritten")
	`PSF_ASSERT_NXT(a_pop_streams, cmd.pop_start, cmd.stream, "pop start without stream")
	`PSF_ASSERT_IMP(a_stream_from_pop, $rose(cmd.stream), $past(pop_take), "stream without pop item")

endmodule
